// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked while reset is released
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define ASSERT_ON(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ASSERT_ON(lbl, clk, prop, msg)
`endif
`endif

// ===== src/whe_pkg.sv =====
// ----------------------------------------------------------------------------
// whe_pkg
// Shared types and constants of the weighted histogram engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package whe_pkg;

  localparam int NUM_BINS_DEF = 1024;

  localparam int X_W      = 32;
  localparam int WGT_W    = 16;
  localparam int QBIN_W   = 10;
  localparam int BCNT_W   = 11;
  localparam int WSUM_W   = 48;
  localparam int SSUM_W   = 64;
  localparam int CFG_IX_W = 4;
  localparam int CFG_D_W  = 32;

  localparam logic [X_W-1:0]    X_MIN_RST     = 32'h0000_0000;
  localparam logic [X_W-1:0]    BIN_WIDTH_RST = 32'h0001_0000;
  localparam logic [X_W-1:0]    INV_BW_RST    = 32'h0001_0000;
  localparam logic [BCNT_W-1:0] BIN_COUNT_RST = 11'd1024;

  localparam logic KIND_FILL  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [CFG_IX_W-1:0] {
    REG_X_MIN         = 4'd0,
    REG_BIN_WIDTH     = 4'd1,
    REG_INV_BIN_WIDTH = 4'd2,
    REG_BIN_COUNT     = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic                    kind;
    logic signed [X_W-1:0]   sample_value;
    logic signed [WGT_W-1:0] weight;
    logic [QBIN_W-1:0]       query_bin;
  } whe_item_t;

  typedef struct packed {
    logic clr_wr;
    logic load_in;
    logic do_find;
    logic do_mul;
    logic do_look;
    logic do_read;
    logic commit;
  } whe_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } whe_sts_t;

endpackage

`default_nettype wire

// ===== src/whe_if.sv =====
// ----------------------------------------------------------------------------
// whe_if
// Valid/ready channels of the engine: input word, result word, config write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface whe_in_if;
  import whe_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [X_W-1:0]   sample_value;
  logic signed [WGT_W-1:0] weight;
  logic [QBIN_W-1:0]       query_bin;
  modport source (output valid, kind, sample_value, weight, query_bin, input ready);
  modport sink   (input valid, kind, sample_value, weight, query_bin, output ready);
endinterface

interface whe_out_if;
  import whe_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     valid_res;
  logic [QBIN_W-1:0]        bin_number;
  logic signed [X_W-1:0]    bin_center;
  logic signed [WSUM_W-1:0] weight_sum;
  logic [SSUM_W-1:0]        square_sum;
  modport source (output valid, valid_res, bin_number, bin_center, weight_sum, square_sum,
                  input ready);
  modport sink   (input valid, valid_res, bin_number, bin_center, weight_sum, square_sum,
                  output ready);
endinterface

interface whe_cfg_if;
  import whe_pkg::*;
  logic                valid;
  logic                ready;
  logic [CFG_IX_W-1:0] index;
  logic [CFG_D_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/whe_ctrl.sv =====
// ----------------------------------------------------------------------------
// whe_ctrl
// Sequencer: clearing sweep, then find, multiply, look-up, read, commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module whe_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  whe_pkg::whe_sts_t sts,
  output whe_pkg::whe_cmd_t cmd
);
  import whe_pkg::*;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_FIND  = 7'b0000100,
    S_MUL   = 7'b0001000,
    S_LOOK  = 7'b0010000,
    S_READ  = 7'b0100000,
    S_CALC  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
        if (in_valid) begin
          state_nxt = S_FIND;
        end
      end
      S_FIND: begin
        cmd.do_find = 1'b1;
        state_nxt   = S_MUL;
      end
      S_MUL: begin
        cmd.do_mul = 1'b1;
        state_nxt  = S_LOOK;
      end
      S_LOOK: begin
        cmd.do_look = 1'b1;
        state_nxt   = S_READ;
      end
      S_READ: begin
        cmd.do_read = 1'b1;
        state_nxt   = S_CALC;
      end
      S_CALC: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  `ASSERT_ON(a_rst_clear, clk, !rst_n |=> state_r == S_CLEAR, "reset must restart clearing")
  `ASSERT_RST(a_calc_hold, clk, rst_n, (state_r == S_CALC && !sts.out_free) |=> state_r == S_CALC, "commit left while output busy")
  `ASSERT_RST(a_commit_idle, clk, rst_n, cmd.commit |=> state_r == S_IDLE, "no return to idle after commit")

endmodule

`default_nettype wire

// ===== src/whe_datapath.sv =====
// ----------------------------------------------------------------------------
// whe_datapath
// Config registers, bin arithmetic, bin sum memories and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module whe_datapath #(
  parameter int NUM_BINS = whe_pkg::NUM_BINS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  whe_pkg::whe_item_t in_item,
  input  whe_pkg::whe_cmd_t  cmd,
  output whe_pkg::whe_sts_t  sts,
  whe_cfg_if.sink            cfg,
  whe_out_if.source          out_ch
);
  import whe_pkg::*;

  localparam int IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int PW    = IDX_W + 33;
  localparam int CW    = IDX_W + 34;

  localparam logic signed [X_W-1:0]    CENT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [X_W-1:0]    CENT_MIN = -32'sh7FFF_FFFF - 32'sd1;
  localparam logic signed [WSUM_W-1:0] WSUM_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [WSUM_W-1:0] WSUM_MIN = 48'sh8000_0000_0000;

  // configuration
  logic signed [X_W-1:0] x_min_r;
  logic [X_W-1:0]        bin_width_r;
  logic [X_W-1:0]        inv_bw_r;
  logic [BCNT_W-1:0]     bin_count_r;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_min_r     <= X_MIN_RST;
      bin_width_r <= BIN_WIDTH_RST;
      inv_bw_r    <= INV_BW_RST;
      bin_count_r <= BIN_COUNT_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_X_MIN:         x_min_r     <= cfg.data;
        REG_BIN_WIDTH:     bin_width_r <= cfg.data;
        REG_INV_BIN_WIDTH: inv_bw_r    <= cfg.data;
        REG_BIN_COUNT:     bin_count_r <= cfg.data[BCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // item and arithmetic stages
  logic                    kind_r;
  logic signed [X_W-1:0]   x_r;
  logic signed [WGT_W-1:0] w_r;
  logic [QBIN_W-1:0]       qbin_r;
  logic signed [X_W:0]     diff_r;
  logic [31:0]             wsq_r;
  logic [63:0]             prod_r;
  logic                    hit_r;
  logic [IDX_W-1:0]        bin_r;
  logic [QBIN_W-1:0]       bin_num_r;
  logic [PW-1:0]           cprod_r;
  logic signed [WSUM_W-1:0] rd_w_r;
  logic [SSUM_W-1:0]       rd_s_r;
  logic [IDX_W-1:0]        clr_cnt_r;

  logic signed [31:0] wsq_s;
  logic [31:0]        lim;
  logic [31:0]        fidx;
  logic               fok;
  logic               qok;
  logic               in_range;
  logic [31:0]        idx;

  assign wsq_s = w_r * w_r;

  assign lim  = (32'(bin_count_r) < 32'(NUM_BINS)) ? 32'(bin_count_r) : 32'(NUM_BINS);
  assign fidx = (inv_bw_r == '0) ? '0 : prod_r[63:32];
  assign fok  = ((inv_bw_r == '0) || !diff_r[X_W]) && (fidx < lim);
  assign qok  = 32'(qbin_r) < lim;
  assign in_range = (kind_r == KIND_QUERY) ? qok : fok;
  assign idx      = (kind_r == KIND_QUERY) ? 32'(qbin_r) : fidx;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= in_item.kind;
      x_r    <= in_item.sample_value;
      w_r    <= in_item.weight;
      qbin_r <= in_item.query_bin;
    end
    if (cmd.do_find) begin
      diff_r <= (X_W+1)'(x_r) - (X_W+1)'(x_min_r);
      wsq_r  <= $unsigned(wsq_s);
    end
    if (cmd.do_mul) begin
      prod_r <= 64'(diff_r[X_W-1:0]) * 64'(inv_bw_r);
    end
    if (cmd.do_look) begin
      hit_r     <= in_range;
      bin_r     <= in_range ? idx[IDX_W-1:0] : '0;
      bin_num_r <= (kind_r == KIND_QUERY) ? qbin_r : (fok ? fidx[QBIN_W-1:0] : '0);
    end
    if (cmd.do_read) begin
      cprod_r <= PW'({bin_r, 1'b1}) * PW'(bin_width_r);
    end
  end

  // clearing sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt_r <= sts.clr_last ? '0 : clr_cnt_r + 1'b1;
    end
  end

  assign sts.clr_last = clr_cnt_r == IDX_W'(NUM_BINS - 1);

  // new sums and centre
  logic signed [WSUM_W:0]   wsum_full;
  logic signed [WSUM_W-1:0] wsum_new;
  logic [SSUM_W:0]          ssum_full;
  logic [SSUM_W-1:0]        ssum_new;
  logic signed [CW-1:0]     cent_full;
  logic signed [X_W-1:0]    cent_sat;
  logic                     is_fill;

  assign is_fill   = kind_r == KIND_FILL;
  assign wsum_full = (WSUM_W+1)'(rd_w_r) + (WSUM_W+1)'(w_r);
  assign ssum_full = (SSUM_W+1)'(rd_s_r) + (SSUM_W+1)'(wsq_r);
  assign ssum_new  = ssum_full[SSUM_W] ? '1 : ssum_full[SSUM_W-1:0];
  assign cent_full = $signed(CW'(x_min_r)) + $signed(CW'(cprod_r[PW-1:1]));

  always_comb begin
    if (wsum_full[WSUM_W] != wsum_full[WSUM_W-1]) begin
      wsum_new = wsum_full[WSUM_W] ? WSUM_MIN : WSUM_MAX;
    end else begin
      wsum_new = wsum_full[WSUM_W-1:0];
    end
    if (cent_full > $signed(CW'(CENT_MAX))) begin
      cent_sat = CENT_MAX;
    end else if (cent_full < $signed(CW'(CENT_MIN))) begin
      cent_sat = CENT_MIN;
    end else begin
      cent_sat = cent_full[X_W-1:0];
    end
  end

  // bin memories
  logic [WSUM_W-1:0] wsum_mem [NUM_BINS];
  logic [SSUM_W-1:0] ssum_mem [NUM_BINS];
  logic              mem_we;
  logic [IDX_W-1:0]  mem_wa;

  assign mem_we = cmd.clr_wr || (cmd.commit && hit_r && is_fill);
  assign mem_wa = cmd.clr_wr ? clr_cnt_r : bin_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      wsum_mem[mem_wa] <= cmd.clr_wr ? '0 : wsum_new;
      ssum_mem[mem_wa] <= cmd.clr_wr ? '0 : ssum_new;
    end
    rd_w_r <= wsum_mem[bin_r];
    rd_s_r <= ssum_mem[bin_r];
  end

  // result register
  logic                     out_valid_r;
  logic                     res_valid_r;
  logic [QBIN_W-1:0]        res_bin_r;
  logic signed [X_W-1:0]    res_cent_r;
  logic signed [WSUM_W-1:0] res_wsum_r;
  logic [SSUM_W-1:0]        res_ssum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_valid_r <= hit_r;
      res_bin_r   <= bin_num_r;
      res_cent_r  <= hit_r ? cent_sat : '0;
      res_wsum_r  <= hit_r ? (is_fill ? wsum_new : rd_w_r) : '0;
      res_ssum_r  <= hit_r ? (is_fill ? ssum_new : rd_s_r) : '0;
    end
  end

  assign sts.out_free      = !out_valid_r || out_ch.ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.valid_res  = res_valid_r;
  assign out_ch.bin_number = res_bin_r;
  assign out_ch.bin_center = res_cent_r;
  assign out_ch.weight_sum = res_wsum_r;
  assign out_ch.square_sum = res_ssum_r;

  `ASSERT_RST(a_commit_out, clk, rst_n, cmd.commit |=> out_valid_r, "result word not posted")
  `ASSERT_RST(a_clr_wrap, clk, rst_n, (cmd.clr_wr && sts.clr_last) |=> clr_cnt_r == '0, "clear counter did not wrap")
  `ASSERT_RST(a_no_wr_busy, clk, rst_n, (cmd.commit && out_valid_r) |-> out_ch.ready, "result overwritten")

endmodule

`default_nettype wire

// ===== src/weighted_histogram_engine.sv =====
// ----------------------------------------------------------------------------
// weighted_histogram_engine
// Uniform-bin weighted histogram with per-bin weight and square-weight sums.
// ----------------------------------------------------------------------------
// After reset the engine clears both bin memories, one bin per cycle, so no
// input word is taken until every bin has been cleared (config writes are
// taken throughout). Each word is latched at the accepting edge and passes
// through subtract, index multiply, range check and memory read, then the
// read-modify-write commit of the bin loads the output register. A new word
// is accepted only once the control is back in idle after the commit, also
// while the output register holds a result; the commit stalls only while an
// earlier result is still waiting to be taken.
`timescale 1ns / 1ps
`default_nettype none

module weighted_histogram_engine #(
  parameter int NUM_BINS = whe_pkg::NUM_BINS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  whe_in_if.sink     in_ch,
  whe_out_if.source  out_ch,
  whe_cfg_if.sink    cfg_ch
);
  import whe_pkg::*;

  whe_item_t in_item;
  whe_cmd_t  cmd;
  whe_sts_t  sts;
  logic      ctl_ready;

  assign in_item.kind         = in_ch.kind;
  assign in_item.sample_value = in_ch.sample_value;
  assign in_item.weight       = in_ch.weight;
  assign in_item.query_bin    = in_ch.query_bin;
  assign in_ch.ready          = ctl_ready;

  whe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (ctl_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  whe_datapath #(
    .NUM_BINS (NUM_BINS)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .cmd     (cmd),
    .sts     (sts),
    .cfg     (cfg_ch),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
